[design/vn_pkg.sv]
// vn_pkg: shared types and constants for the vector normalizer
// no dependencies; used by vn_front, vn_step, vector3_normalise_top and tb by scoped names
package vn_pkg;

	localparam int CFG_W = 32;
	localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 32'd1;

	// per-word control that travels along the pipeline
	typedef struct packed {
		logic       valid;
		logic       too_short;
		logic [2:0] neg;
	} vn_ctl_t;

endpackage

[design/vn_in_if.sv]
// vn_in_if: input channel carrying one signed vector word
// no dependencies
interface vn_in_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] x_in;
	logic signed [W-1:0] y_in;
	logic signed [W-1:0] z_in;

	modport source (output valid, x_in, y_in, z_in, input ready);
	modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

[design/vn_out_if.sv]
// vn_out_if: output channel carrying one normalized vector word
// no dependencies
interface vn_out_if #(parameter int OW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [OW-1:0] x_out;
	logic signed [OW-1:0] y_out;
	logic signed [OW-1:0] z_out;
	logic                 too_short;

	modport source (output valid, x_out, y_out, z_out, too_short, input ready);
	modport sink   (input valid, x_out, y_out, z_out, too_short, output ready);
endinterface

[design/vn_front.sv]
// vn_front: magnitudes, squares, squared length and short test (three stages)
// depends on vn_pkg
module vn_front #(
	parameter int W = 32,
	parameter int F = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [W-1:0]          x,
	input  logic [W-1:0]          y,
	input  logic [W-1:0]          z,
	input  logic [vn_pkg::CFG_W-1:0] min_length,
	output vn_pkg::vn_ctl_t       ctl_s3,
	output logic [2*W-1:0]        s_s3,
	output logic [2:0][2*W+2*F+4:0] r_s3
);
	localparam int SW = 2 * W;
	localparam int CW = 2 * W + 2 * F + 5;
	localparam int LW = 2 * vn_pkg::CFG_W;
	localparam int MW = (SW > LW) ? SW : LW;

	logic [2:0][W-1:0] raw;
	logic [2:0][W-1:0] mag_s1;
	logic [2:0][SW-1:0] sq_s2;
	logic [LW-1:0]      min_sq_s2;
	vn_pkg::vn_ctl_t    ctl_s1, ctl_s2;
	logic [SW-1:0]      sum;

	assign raw = {z, y, x};
	assign sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1.valid     <= in_valid;
			ctl_s1.too_short <= 1'b0;
			for (int i = 0; i < 3; i++) ctl_s1.neg[i] <= raw[i][W-1];
			ctl_s2           <= ctl_s1;
			ctl_s3.valid     <= ctl_s2.valid;
			ctl_s3.neg       <= ctl_s2.neg;
			ctl_s3.too_short <= MW'(sum) <= MW'(min_sq_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				// exact magnitude, the most negative value included
				mag_s1[i] <= raw[i][W-1] ? (~raw[i] + 1'b1) : raw[i];
				sq_s2[i]  <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
				// (2 * mag * 2^F)^2
				r_s3[i]   <= CW'(sq_s2[i]) << (2 * F + 2);
			end
			min_sq_s2 <= LW'(min_length) * LW'(min_length);
			s_s3      <= sum;
		end
	end
endmodule

[design/vn_step.sv]
// vn_step: one registered bit step of the ratio search for all three lanes
// depends on vn_pkg
module vn_step #(
	parameter int W = 32,
	parameter int F = 30,
	parameter int K = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  vn_pkg::vn_ctl_t         ctl_d,
	input  logic [2*W-1:0]          s_d,
	input  logic [2:0][2*W+2*F+4:0] r_d,
	input  logic [2:0][2*W+2*F+4:0] u_d,
	input  logic [2:0][F+1:0]       m_d,
	output vn_pkg::vn_ctl_t         ctl_q,
	output logic [2*W-1:0]          s_q,
	output logic [2:0][2*W+2*F+4:0] r_q,
	output logic [2:0][2*W+2*F+4:0] u_q,
	output logic [2:0][F+1:0]       m_q
);
	localparam int CW = 2 * W + 2 * F + 5;
	localparam int MB = F + 2;

	logic [2:0][CW-1:0] trial;
	logic [2:0]         take;

	// setting bit K of m grows m^2*S by 2^(K+1)*m*S + 2^(2K)*S
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = (u_d[i] << (K + 1)) + (CW'(s_d) << (2 * K));
			take[i]  = r_d[i] >= trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_q <= s_d;
			for (int i = 0; i < 3; i++) begin
				r_q[i] <= take[i] ? (r_d[i] - trial[i]) : r_d[i];
				u_q[i] <= take[i] ? (u_d[i] + (CW'(s_d) << K)) : u_d[i];
				m_q[i] <= take[i] ? (m_d[i] | (MB'(1) << K)) : m_d[i];
			end
		end
	end
endmodule

[design/vector3_normalise_top.sv]
// vector3_normalise_top: pipelined exact normalizer of signed fixed-point 3-vectors
// depends on vn_pkg, vn_in_if, vn_out_if, vn_front, vn_step
//
// usage
//   in_ch carries one word per vector: x_in, y_in, z_in, signed Q16.16
//   out_ch carries one word per input word, in order: x_out, y_out, z_out in
//   signed Q1.OUT_FRAC_BITS rounded to nearest (half away from zero), and
//   too_short, set with all components zero when length <= min_length
//   cfg_we / cfg_wdata write min_length (raw input lsb units); write only
//   while the pipeline is empty
// timing
//   latency is OUT_FRAC_BITS + 6 cycles (36 at the defaults): three front
//   stages, one stage per quotient bit (OUT_FRAC_BITS + 2), one output stage
//   one word per cycle is accepted when the output is free or being taken
// reset
//   arst_n clears every valid bit and sets min_length to 1
// stall
//   when out_ch.ready is low with a word waiting, the whole pipeline holds
//   and in_ch.ready drops in the same cycle; nothing is lost or repeated
module vector3_normalise_top #(
	parameter int IN_WIDTH      = 32,
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vn_pkg::CFG_W-1:0]     cfg_wdata,
	vn_in_if.sink                        in_ch,
	vn_out_if.source                     out_ch
);
	localparam int W  = IN_WIDTH;
	localparam int F  = OUT_FRAC_BITS;
	localparam int SW = 2 * W;
	localparam int CW = 2 * W + 2 * F + 5;
	localparam int MB = F + 2;
	localparam int NS = F + 2;   // one step per bit of m

	logic [vn_pkg::CFG_W-1:0] min_length_q;
	logic                     en;

	// step chain buses, index j feeds step j
	vn_pkg::vn_ctl_t          ctl   [NS+1];
	logic [SW-1:0]            s     [NS+1];
	logic [2:0][CW-1:0]       r     [NS+1];
	logic [2:0][CW-1:0]       u     [NS+1];
	logic [2:0][MB-1:0]       m     [NS+1];

	logic [2:0][MB:0]         mp1;
	logic [2:0][MB-1:0]       q;
	logic [2:0][MB-1:0]       res;

	// the output register is the last stage; the pipe moves when it is free or being taken
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= vn_pkg::MIN_LENGTH_RESET;
		end else if (cfg_we) begin
			min_length_q <= cfg_wdata;
		end
	end

	vn_front #(.W(W), .F(F)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_ch.valid),
		.x          (in_ch.x_in),
		.y          (in_ch.y_in),
		.z          (in_ch.z_in),
		.min_length (min_length_q),
		.ctl_s3     (ctl[0]),
		.s_s3       (s[0]),
		.r_s3       (r[0])
	);

	// search starts from m = 0, so m*S = 0
	assign u[0] = '0;
	assign m[0] = '0;

	// m = floor(2*|c|*2^F / sqrt(S)), found msb first
	for (genvar j = 0; j < NS; j++) begin : g_step
		vn_step #(.W(W), .F(F), .K(NS - 1 - j)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_d  (ctl[j]),
			.s_d    (s[j]),
			.r_d    (r[j]),
			.u_d    (u[j]),
			.m_d    (m[j]),
			.ctl_q  (ctl[j+1]),
			.s_q    (s[j+1]),
			.r_q    (r[j+1]),
			.u_q    (u[j+1]),
			.m_q    (m[j+1])
		);
	end

	// largest q with 2q-1 <= m, then sign; zero when short
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mp1[i] = (MB + 1)'(m[NS][i]) + 1'b1;
			q[i]   = mp1[i][MB:1];
			if (ctl[NS].too_short) begin
				res[i] = '0;
			end else if (ctl[NS].neg[i]) begin
				res[i] = ~q[i] + 1'b1;
			end else begin
				res[i] = q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= ctl[NS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.x_out     <= res[0];
			out_ch.y_out     <= res[1];
			out_ch.z_out     <= res[2];
			out_ch.too_short <= ctl[NS].too_short;
		end
	end
endmodule

[design/vn_checker.sv]
// vn_checker: port-level assertions for the vector normalizer, bound to the top
// depends on vector3_normalise_top
module vn_checker #(
	parameter int F = 30
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [F+1:0]  x_out,
	input logic signed [F+1:0]  y_out,
	input logic signed [F+1:0]  z_out,
	input logic                 too_short
);
	localparam logic signed [F+1:0] LIM = {1'b0, 1'b1, {F{1'b0}}};

	// word waits while stalled
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(x_out) && $stable(y_out) && $stable(z_out)
			&& $stable(too_short))
		else $error("output word changed while stalled");

	// input side follows the output register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not track output slot");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_short |-> x_out == '0 && y_out == '0 && z_out == '0)
		else $error("short vector with nonzero components");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_out <= LIM && x_out >= -LIM && y_out <= LIM && y_out >= -LIM
			&& z_out <= LIM && z_out >= -LIM)
		else $error("component outside unit range");
endmodule

bind vector3_normalise_top vn_checker #(.F(OUT_FRAC_BITS)) u_vn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.x_out     (out_ch.x_out),
	.y_out     (out_ch.y_out),
	.z_out     (out_ch.z_out),
	.too_short (out_ch.too_short)
);

[tb/tb.sv]
// tb: testbench for vector3_normalise_top, exact vector normalizer
// depends on vn_pkg, vn_in_if, vn_out_if and the design files
`timescale 1ns / 1ps

module tb;

	localparam int IN_W  = 32;
	localparam int FRAC  = 30;
	localparam int OUT_W = FRAC + 2;
	localparam int LATENCY = FRAC + 6;

	typedef struct packed {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
		logic             too_short;
	} unit_vec_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vn_pkg::CFG_W-1:0] cfg_wdata;

	vn_in_if  #(.W(IN_W))   in_ch ();
	vn_out_if #(.OW(OUT_W)) out_ch ();

	vector3_normalise_top #(.IN_WIDTH(IN_W), .OUT_FRAC_BITS(FRAC)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// model copy of the register
	logic [31:0] min_len_model;
	unit_vec_t   expected_units[$];
	int          fail_count;
	// idling percentages: 0 gives a stretch with no idling
	int          send_idle_pct;
	int          take_idle_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// safety net: far beyond the slowest correct run
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [31:0] abs_comp(logic [31:0] c);
		return c[31] ? (~c + 32'd1) : c;
	endfunction

	// largest q in [0, 2^FRAC] with (2q-1)^2 * s <= 4 * a^2 * 2^(2 FRAC)
	function automatic logic [FRAC:0] scaled_ratio(logic [31:0] a, logic [65:0] s);
		logic [255:0] rhs;
		logic [255:0] lhs;
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [63:0]  mid;
		logic [63:0]  odd;
		rhs = 256'(a) * 256'(a);
		rhs = rhs << (2 * FRAC + 2);
		lo = 0;
		hi = 64'd1 << FRAC;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			lhs = 256'(odd) * 256'(odd) * 256'(s);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo[FRAC:0];
	endfunction

	function automatic unit_vec_t normalise_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		unit_vec_t   r;
		logic [31:0] m[3];
		logic [2:0]  neg;
		logic [65:0] s;
		logic [63:0] lim;
		logic [OUT_W-1:0] q[3];
		m[0] = abs_comp(x); m[1] = abs_comp(y); m[2] = abs_comp(z);
		neg = {z[31], y[31], x[31]};
		s = 66'(m[0]) * m[0] + 66'(m[1]) * m[1] + 66'(m[2]) * m[2];
		lim = 64'(min_len_model) * 64'(min_len_model);
		r = '0;
		if (s <= 66'(lim)) begin
			r.too_short = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q[i] = OUT_W'(scaled_ratio(m[i], s));
			if (neg[i]) q[i] = -q[i];
		end
		r.x = q[0]; r.y = q[1]; r.z = q[2];
		return r;
	endfunction

	// one word, held until the block takes it
	task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.x_in  <= x;
		in_ch.y_in  <= y;
		in_ch.z_in  <= z;
		expected_units.push_back(normalise_vec(x, y, z));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_ch.valid <= 1'b0;
		while (expected_units.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_min_length(logic [31:0] v);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		min_len_model = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random component with varied magnitude so every bit flips
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5, 0))
			0: return $urandom_range(255, 0) - 128;
			1: return $urandom_range(65535, 0) - 32768;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// output side: random stalls, compare each word with the oldest expectation
	always @(negedge clk) begin
		out_ch.ready <= !(take_idle_pct > 0 && $urandom_range(99, 0) < take_idle_pct);
	end

	always @(posedge clk) begin
		unit_vec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected word x=%h y=%h z=%h short=%b", $time,
					out_ch.x_out, out_ch.y_out, out_ch.z_out, out_ch.too_short);
				fail_count++;
			end else begin
				want = expected_units.pop_front();
				if (out_ch.x_out !== want.x || out_ch.y_out !== want.y ||
					out_ch.z_out !== want.z || out_ch.too_short !== want.too_short) begin
					$display("%0t: mismatch exp x=%h y=%h z=%h short=%b got x=%h y=%h z=%h short=%b",
						$time, want.x, want.y, want.z, want.too_short,
						out_ch.x_out, out_ch.y_out, out_ch.z_out, out_ch.too_short);
					fail_count++;
				end
			end
		end
	end

	task automatic test_axes_and_extremes();
		send_vector(0, 0, 0);
		send_vector(32'h0001_0000, 0, 0);
		send_vector(0, 32'hffff_0000, 0);
		send_vector(0, 0, 32'h8000_0000);
		send_vector(32'h7fff_ffff, 0, 0);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vector(32'h7fff_ffff, 32'h8000_0000, 1);
		send_vector(1, 1, 1);
		send_vector(3, 4, 0);
		send_vector(-3, 0, 4);
		send_vector(1, 0, 0);
		send_vector(1, 1, 0);
		send_vector(2, 2, 1);
	endtask

	// lengths right at the threshold, above and below
	task automatic test_short_threshold();
		write_min_length(5);
		send_vector(3, 4, 0);
		send_vector(3, 4, 1);
		send_vector(0, 0, -5);
		send_vector(0, 0, 6);
		write_min_length(0);
		send_vector(0, 0, 0);
		send_vector(0, 1, 0);
		write_min_length(32'hffff_ffff);
		send_vector(32'h7fff_ffff, 0, 0);
		send_vector(32'h8000_0000, 0, 0);
		send_vector(32'h8000_0000, 1, 0);
	endtask

	task automatic test_random_vectors(int count);
		for (int i = 0; i < count; i++)
			send_vector(rand_comp(), rand_comp(), rand_comp());
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.x_in   = '0;
		in_ch.y_in   = '0;
		in_ch.z_in   = '0;
		out_ch.ready = 1'b0;
		fail_count   = 0;
		min_len_model = vn_pkg::MIN_LENGTH_RESET;
		send_idle_pct = 20;
		take_idle_pct = 20;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_axes_and_extremes();
		test_short_threshold();

		// mid-range threshold with idling, then a back-to-back stretch
		write_min_length(32'h0001_0000);
		test_random_vectors(250);
		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random_vectors(200);
		send_idle_pct = 20;
		take_idle_pct = 20;
		write_min_length($urandom);
		test_random_vectors(150);
		write_min_length(1);
		test_random_vectors(200);

		drain_pipeline();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
design/vn_pkg.sv
design/vn_in_if.sv
design/vn_out_if.sv
design/vn_front.sv
design/vn_step.sv
design/vector3_normalise_top.sv
design/vn_checker.sv
tb/tb.sv
